// File: rtl/itoa_pkg.sv
// shared constants, types and helpers for the integer to ascii digits block
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_HEX  = 2'd1;

    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h61;

    // control bundle from the sequencer to the digit unit
    typedef struct packed {
        logic load;
        logic hex;
        logic step;
        logic shift;
    } itoa_ctl_t;

    // decimal digits needed for the largest unsigned value of w bits
    function automatic int decimal_digits(input int w);
        decimal_digits = (w * 30103) / 100000 + 1;
    endfunction

    function automatic logic [6:0] to_ascii(input logic [3:0] d);
        logic [6:0] d7;
        d7 = {3'b000, d};
        if (d < 4'd10)
        begin
            to_ascii = CHAR_ZERO + d7;
        end
        else
        begin
            to_ascii = CHAR_A + d7 - 7'd10;
        end
    endfunction

endpackage

// File: rtl/itoa_ifs.sv
// valid/ready channel interfaces for the input and output transactions
interface itoa_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: rtl/integer_to_ascii_digits.sv
// top level: integer to ascii text converter, most significant character first
// flow: decimal first runs the shift and add-3 conversion over the value bits, hex skips
//   it; then the digit positions are walked, leading zeros skipped, others sent, a minus first
// a new value is taken only once the last character of the previous one is in the output
//   register; output stalls hold the flow
// reset (rst_n, asynchronous, active low) returns the sequencer to idle, output empty
module integer_to_ascii_digits
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    in_ch,
    itoa_out_if.source out_ch
);

    localparam int ND = decimal_digits(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int RW = $clog2(ND + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic [RW-1:0]          rem_reg;
    logic [RW-1:0]          rem_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   started_reg;
    logic                   started_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [6:0]             ch_reg;
    logic [6:0]             ch_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   accept;
    logic                   slot_free;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] u_in;
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             top_digit;
    itoa_ctl_t              ctl;

    // a new transaction is taken once the last character is in the output register
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    // output register free when empty or being taken this cycle
    assign slot_free   = !out_valid_reg || out_ch.ready;

    // sign handling: only signed decimal looks at the top bit
    assign u_in   = $unsigned(in_ch.value);
    assign neg_in = (in_ch.op == OP_SDEC) && u_in[VALUE_WIDTH-1];
    assign mag    = neg_in ? (~u_in + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : u_in;

    itoa_digit_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (ND)
    ) u_digit (
        .clk       (clk),
        .ctl       (ctl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        ch_next        = ch_reg;
        last_next      = last_reg;
        ctl            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.load     = 1'b1;
                    ctl.hex      = (in_ch.op == OP_HEX);
                    neg_next     = neg_in;
                    started_next = 1'b0;
                    cnt_next     = CW'(VALUE_WIDTH);
                    rem_next     = RW'(ND);
                    // hex digits are the nibbles themselves
                    state_next   = (in_ch.op == OP_HEX) ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // minus sign goes out first, leading zero skip may run alongside
                if (neg_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    ch_next        = CHAR_MINUS;
                    last_next      = 1'b0;
                    neg_next       = 1'b0;
                end
                if (!started_reg && top_digit == 4'h0 && rem_reg != RW'(1))
                begin
                    ctl.shift = 1'b1;
                    rem_next  = rem_reg - RW'(1);
                end
                else if (!neg_reg && slot_free)
                begin
                    ctl.shift      = 1'b1;
                    rem_next       = rem_reg - RW'(1);
                    started_next   = 1'b1;
                    out_valid_next = 1'b1;
                    ch_next        = to_ascii(top_digit);
                    last_next      = (rem_reg == RW'(1));
                    if (rem_reg == RW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.ch    = ch_reg;
    assign out_ch.last  = last_reg;

`ifndef SYNTHESIS
    // no second transaction while one is being converted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input accepted again while converting");

    // the bit counter never runs dry during conversion
    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> cnt_reg != '0)
        else $error("conversion counter reached zero in conversion");

    // a digit always remains while emitting
    a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> rem_reg != '0)
        else $error("no digit left while emitting");

    // a minus sign is never flagged as the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ch == CHAR_MINUS |-> !out_ch.last)
        else $error("minus sign flagged as last");
`endif

endmodule

// File: rtl/itoa_digit_unit.sv
// shared shift and add-3 unit holding the binary and digit registers
module itoa_digit_unit
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = decimal_digits(VALUE_WIDTH)
) (
    input  logic                   clk,
    input  itoa_ctl_t              ctl,
    input  logic [VALUE_WIDTH-1:0] mag,
    output logic [3:0]             top_digit
);

    localparam int DW = 4 * NUM_DIGITS;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [DW-1:0]          dig_reg;
    logic [DW-1:0]          dig_next;
    logic [DW-1:0]          adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        dig_next = dig_reg;
        if (ctl.load)
        begin
            bin_next = mag;
            dig_next = ctl.hex ? DW'(mag) : '0;
        end
        else if (ctl.step)
        begin
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            dig_next = {adj[DW-2:0], bin_reg[VALUE_WIDTH-1]};
        end
        else if (ctl.shift)
        begin
            dig_next = {dig_reg[DW-5:0], 4'h0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
    end

    assign top_digit = dig_reg[DW-1 -: 4];

endmodule
